/* design/hbrp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP byte range parser package
// Shared widths, codes and the result record type.
// ----------------------------------------------------------------------------
package hbrp_pkg;

	localparam int unsigned POS_W          = 31;
	localparam int unsigned VAL_W          = 34;
	localparam int unsigned CNT_W          = 4;
	localparam int unsigned CHAR_W         = 8;
	localparam int unsigned KIND_W         = 2;
	localparam int unsigned MAX_DIGITS_DEF = 10;

	localparam logic [POS_W-1:0] LIMIT_RESET = {POS_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  first_byte;
		logic              has_first;
		logic [POS_W-1:0]  last_byte;
		logic              has_last;
		logic              final_res;
	} result_t;

endpackage

/* design/hbrp_parse.sv */
// ----------------------------------------------------------------------------
// HTTP byte range parser state and next-state logic
// Consumes one character per cycle with beat set; yields up to two result records.
// ----------------------------------------------------------------------------
module hbrp_parse import hbrp_pkg::*; #(
	parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [POS_W-1:0]  cfg_limit,
	input  logic              beat,
	input  logic [CHAR_W-1:0] character,
	input  logic              end_marker,
	output result_t           res0,
	output result_t           res1,
	output logic [1:0]        res_cnt
);

	logic [POS_W-1:0] limit_q;
	logic [VAL_W-1:0] dv_q, dv_d;
	logic [CNT_W-1:0] dc_q, dc_d;
	logic             pv_q, pv_d;
	logic [POS_W-1:0] pf_q, pf_d;
	logic             pfv_q, pfv_d;
	logic [POS_W-1:0] pl_q, pl_d;
	logic             plv_q, plv_d;
	logic             dash_q, dash_d;
	logic             pwc_q, pwc_d;
	logic             fail_q, fail_d;
	logic [POS_W-1:0] cf_q, cf_d;
	logic             cfv_q, cfv_d;

	logic             close_ok;
	logic [POS_W-1:0] close_pl;
	logic             close_plv;
	logic             over_limit;
	logic [VAL_W-1:0] dv_next;

	assign over_limit = dv_q > {{(VAL_W-POS_W){1'b0}}, limit_q};
	assign dv_next    = {dv_q[VAL_W-4:0], 3'b000} + {dv_q[VAL_W-2:0], 1'b0}
		+ {{(VAL_W-4){1'b0}}, character[3:0]};

	always_comb begin
		close_ok  = 1'b1;
		close_pl  = pl_q;
		close_plv = plv_q;
		if (dc_q != '0) begin
			close_ok = dash_q && !over_limit
				&& !(cfv_q && (dv_q < {{(VAL_W-POS_W){1'b0}}, cf_q}));
			if (!plv_q || (dv_q > {{(VAL_W-POS_W){1'b0}}, pl_q})) begin
				close_pl  = dv_q[POS_W-1:0];
				close_plv = 1'b1;
			end
		end else if (dash_q) begin
			close_ok  = cfv_q;
			close_plv = 1'b0;
		end
	end

	function automatic result_t range_rec(input logic [POS_W-1:0] f, input logic hf,
		input logic [POS_W-1:0] l, input logic hl);
		result_t r;
		r.kind       = KIND_RANGE;
		r.first_byte = hf ? f : '0;
		r.has_first  = hf;
		r.last_byte  = hl ? l : '0;
		r.has_last   = hl;
		r.final_res  = 1'b0;
		return r;
	endfunction

	function automatic result_t status_rec(input logic [KIND_W-1:0] k);
		result_t r;
		r           = '0;
		r.kind      = k;
		r.final_res = 1'b1;
		return r;
	endfunction

	always_comb begin
		dv_d    = dv_q;
		dc_d    = dc_q;
		pv_d    = pv_q;
		pf_d    = pf_q;
		pfv_d   = pfv_q;
		pl_d    = pl_q;
		plv_d   = plv_q;
		dash_d  = dash_q;
		pwc_d   = pwc_q;
		fail_d  = fail_q;
		cf_d    = cf_q;
		cfv_d   = cfv_q;
		res0    = '0;
		res1    = '0;
		res_cnt = 2'd0;
		if (end_marker) begin
			if (!fail_q && close_ok && pv_q) begin
				res0    = range_rec(pf_q, pfv_q, close_pl, close_plv);
				res1    = status_rec(KIND_ACCEPT);
				res_cnt = 2'd2;
			end else begin
				res0    = status_rec(KIND_REJECT);
				res_cnt = 2'd1;
			end
			dv_d   = '0;
			dc_d   = '0;
			pv_d   = 1'b0;
			pf_d   = '0;
			pfv_d  = 1'b0;
			pl_d   = '0;
			plv_d  = 1'b0;
			dash_d = 1'b0;
			pwc_d  = 1'b0;
			fail_d = 1'b0;
			cf_d   = '0;
			cfv_d  = 1'b0;
		end else if (!fail_q) begin
			if (character >= CH_ZERO && character <= CH_NINE) begin
				if (dc_q >= CNT_W'(MAX_DIGITS)) begin
					fail_d = 1'b1;
				end else begin
					dv_d = dv_next;
					dc_d = dc_q + CNT_W'(1);
				end
				pwc_d = 1'b0;
			end else if (character == CH_DASH) begin
				pwc_d = 1'b0;
				if (dash_q || (pv_q && (!plv_q || !pfv_q))) begin
					fail_d = 1'b1;
				end else if ((dc_q != '0) && (over_limit
					|| (pv_q && ({{(VAL_W-POS_W){1'b0}}, pf_q} > dv_q)))) begin
					fail_d = 1'b1;
				end else if ((dc_q != '0) && pv_q
					&& ({{(VAL_W-POS_W){1'b0}}, pl_q} >= dv_q)) begin
					cf_d   = dv_q[POS_W-1:0];
					cfv_d  = 1'b1;
					dash_d = 1'b1;
					dv_d   = '0;
					dc_d   = '0;
				end else begin
					cf_d  = (dc_q != '0) ? dv_q[POS_W-1:0] : '0;
					cfv_d = dc_q != '0;
					if (pv_q) begin
						res0    = range_rec(pf_q, pfv_q, pl_q, plv_q);
						res_cnt = 2'd1;
					end
					pv_d   = 1'b1;
					pf_d   = cf_d;
					pfv_d  = cfv_d;
					pl_d   = '0;
					plv_d  = 1'b0;
					dash_d = 1'b1;
					dv_d   = '0;
					dc_d   = '0;
				end
			end else if (character == CH_COMMA) begin
				if (!close_ok) begin
					fail_d = 1'b1;
				end else begin
					pl_d   = close_pl;
					plv_d  = close_plv;
					dash_d = 1'b0;
					dv_d   = '0;
					dc_d   = '0;
				end
				pwc_d = 1'b1;
			end else if (character == CH_SPACE) begin
				if (!pwc_q) begin
					fail_d = 1'b1;
				end
				pwc_d = 1'b0;
			end else begin
				fail_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q   <= '0;
			dc_q   <= '0;
			pv_q   <= 1'b0;
			pf_q   <= '0;
			pfv_q  <= 1'b0;
			pl_q   <= '0;
			plv_q  <= 1'b0;
			dash_q <= 1'b0;
			pwc_q  <= 1'b0;
			fail_q <= 1'b0;
			cf_q   <= '0;
			cfv_q  <= 1'b0;
		end else if (beat) begin
			dv_q   <= dv_d;
			dc_q   <= dc_d;
			pv_q   <= pv_d;
			pf_q   <= pf_d;
			pfv_q  <= pfv_d;
			pl_q   <= pl_d;
			plv_q  <= plv_d;
			dash_q <= dash_d;
			pwc_q  <= pwc_d;
			fail_q <= fail_d;
			cf_q   <= cf_d;
			cfv_q  <= cfv_d;
		end
	end

endmodule

/* design/hbrp_queue.sv */
// ----------------------------------------------------------------------------
// HTTP byte range parser result queue
// Four-entry shifting queue that takes up to two records per cycle.
// ----------------------------------------------------------------------------
module hbrp_queue import hbrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_cnt,
	input  result_t    push0,
	input  result_t    push1,
	input  logic       pop,
	output logic       room,
	output logic       head_valid,
	output result_t    head
);

	localparam int unsigned DEPTH = 4;

	result_t    ent_q [DEPTH];
	result_t    ent_d [DEPTH];
	logic [2:0] cnt_q;
	logic [2:0] base;
	logic [1:0] n_in;

	assign head_valid = cnt_q != 3'd0;
	assign head       = ent_q[0];
	assign room       = cnt_q <= 3'd2;
	assign n_in       = push ? push_cnt : 2'd0;
	assign base       = cnt_q - {2'b00, pop};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_d[i] = (pop && (i < DEPTH - 1)) ? ent_q[(i + 1) % DEPTH] : ent_q[i];
			if ((n_in != 2'd0) && (3'(i) == base)) begin
				ent_d[i] = push0;
			end
			if ((n_in == 2'd2) && (3'(i) == base + 3'd1)) begin
				ent_d[i] = push1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + {1'b0, n_in};
		end
	end

endmodule

/* design/http_byte_range_parser_unit.sv */
// ----------------------------------------------------------------------------
// HTTP byte range parser unit
// Parses the characters after "bytes=" into byte range records and a status.
// ----------------------------------------------------------------------------
// One header character enters per beat on the slave side, and a beat with
// tlast set closes the header; its character is ignored. Every beat is
// handled as it arrives, so a new character can be taken each cycle.
// Results leave through a four-entry queue: a range record has tuser zero,
// and the closing status beat carries tlast with tuser one for accepted or
// two for rejected. The slave side stalls only while that queue holds more
// than two records. On a rejected header the consumer drops the ranges it
// has already received. The user must write the position limit on the cfg
// channel only while the unit is idle; the unit does not enforce this.
module http_byte_range_parser_unit import hbrp_pkg::*; #(
	parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [POS_W-1:0]  cfg_data,     // position_limit
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,      // character
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,      // first_byte, has_first, last_byte, has_last
	output logic [KIND_W-1:0] m_tuser,      // kind
	output logic              m_tlast
);

	logic       beat;
	logic       room;
	result_t    res0;
	result_t    res1;
	logic [1:0] res_cnt;
	result_t    head;

	assign cfg_ready = 1'b1;
	assign s_tready  = room;
	assign beat      = s_tvalid && room;

	hbrp_parse #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_limit (cfg_data),
		.beat      (beat),
		.character (s_tdata),
		.end_marker(s_tlast),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt)
	);

	hbrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (beat),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (m_tvalid && m_tready),
		.room      (room),
		.head_valid(m_tvalid),
		.head      (head)
	);

	assign m_tdata = {head.has_last, head.last_byte, head.has_first, head.first_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.final_res;

endmodule

/* design/hbrp_checker.sv */
// ----------------------------------------------------------------------------
// HTTP byte range parser port checker
// Watches the result stream of the unit for malformed beats.
// ----------------------------------------------------------------------------
module hbrp_port_checker import hbrp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [63:0]       m_tdata,
	input logic [KIND_W-1:0] m_tuser,
	input logic              m_tlast
);

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == KIND_ACCEPT || m_tuser == KIND_REJECT))
		else $error("Status beat carries a range kind.");

	a_range_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == KIND_RANGE)
		else $error("Range beat carries a status kind.");

	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == '0)
		else $error("Status beat carries range data.");

	a_no_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[31] |-> m_tdata[30:0] == '0
			&& (m_tdata[63] || m_tdata[62:32] == '0))
		else $error("Absent position is not zero.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled result beat changed.");

endmodule

bind http_byte_range_parser_unit hbrp_port_checker u_hbrp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

/* dv/hbrp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP byte range parser checker
// Follows the character and limit beats going into the unit, works out the
// range and status records they must produce, and compares every output
// beat field by field with the oldest record still due.
// ----------------------------------------------------------------------------
module hbrp_checker import hbrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [POS_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [63:0]       m_tdata,
	input  logic [KIND_W-1:0] m_tuser,
	input  logic              m_tlast,
	output int unsigned       fail_count,
	output int unsigned       records_due
);

	bit [POS_W-1:0] pos_limit = LIMIT_RESET;
	bit [VAL_W-1:0] num_acc;
	int unsigned    num_digits;
	bit             span_open;
	bit             span_has_first;
	bit             span_has_last;
	bit [VAL_W-1:0] span_first;
	bit [VAL_W-1:0] span_last;
	bit [VAL_W-1:0] spec_first;
	bit             spec_has_first;
	bit             dash_in_spec;
	bit             after_comma;
	bit             header_bad;
	result_t        due_records[$];
	result_t        got_rec;
	result_t        want_rec;
	int unsigned    out_beats;

	function automatic void restart_header();
		num_acc        = '0;
		num_digits     = 0;
		span_open      = 1'b0;
		span_has_first = 1'b0;
		span_has_last  = 1'b0;
		span_first     = '0;
		span_last      = '0;
		spec_first     = '0;
		spec_has_first = 1'b0;
		dash_in_spec   = 1'b0;
		after_comma    = 1'b0;
		header_bad     = 1'b0;
	endfunction

	function automatic void queue_record(input logic [KIND_W-1:0] kind, input bit with_span,
			input bit last_beat);
		result_t rec;
		rec = '0;
		rec.kind = kind;
		if (with_span) begin
			rec.has_first  = span_has_first;
			rec.first_byte = span_has_first ? span_first[POS_W-1:0] : '0;
			rec.has_last   = span_has_last;
			rec.last_byte  = span_has_last ? span_last[POS_W-1:0] : '0;
		end
		rec.final_res = last_beat;
		due_records.push_back(rec);
	endfunction

	// Closes the spec in progress at a comma or at the end of the header.
	function automatic bit finish_spec();
		if (num_digits > 0) begin
			if (!dash_in_spec || num_acc > pos_limit) return 1'b0;
			if (spec_has_first && num_acc < spec_first) return 1'b0;
			if (!span_has_last || num_acc > span_last) begin
				span_last     = num_acc;
				span_has_last = 1'b1;
			end
		end else if (dash_in_spec) begin
			if (!spec_has_first) return 1'b0;
			span_has_last = 1'b0;
		end
		dash_in_spec = 1'b0;
		num_acc      = '0;
		num_digits   = 0;
		return 1'b1;
	endfunction

	task automatic parse_header_char(input logic [CHAR_W-1:0] ch, input logic close);
		bit             ok;
		bit [VAL_W-1:0] v;
		if (close) begin
			ok = !header_bad && finish_spec() && span_open;
			if (ok) queue_record(KIND_RANGE, 1'b1, 1'b0);
			queue_record(ok ? KIND_ACCEPT : KIND_REJECT, 1'b0, 1'b1);
			restart_header();
		end else if (!header_bad) begin
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				if (num_digits >= MAX_DIGITS_DEF) begin
					header_bad = 1'b1;
				end else begin
					num_acc = num_acc * 10 + (ch - CH_ZERO);
					num_digits++;
				end
				after_comma = 1'b0;
			end else if (ch == CH_DASH) begin
				after_comma = 1'b0;
				v = num_acc;
				if (dash_in_spec || (span_open && (!span_has_last || !span_has_first))) begin
					header_bad = 1'b1;
				end else if (num_digits > 0 && (v > pos_limit || (span_open && span_first > v))) begin
					header_bad = 1'b1;
				end else if (num_digits > 0 && span_open && span_last >= v) begin
					// The new spec starts inside the pending range and merges into it.
					spec_first     = v;
					spec_has_first = 1'b1;
					dash_in_spec   = 1'b1;
					num_acc        = '0;
					num_digits     = 0;
				end else begin
					spec_first     = (num_digits > 0) ? v : '0;
					spec_has_first = (num_digits > 0);
					if (span_open) queue_record(KIND_RANGE, 1'b1, 1'b0);
					span_open      = 1'b1;
					span_first     = spec_first;
					span_has_first = spec_has_first;
					span_last      = '0;
					span_has_last  = 1'b0;
					dash_in_spec   = 1'b1;
					num_acc        = '0;
					num_digits     = 0;
				end
			end else if (ch == CH_COMMA) begin
				if (!finish_spec()) header_bad = 1'b1;
				after_comma = 1'b1;
			end else if (ch == CH_SPACE) begin
				if (!after_comma) header_bad = 1'b1;
				after_comma = 1'b0;
			end else begin
				header_bad = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("output beat %0d: %s is %0h, expected %0h", out_beats, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) pos_limit = cfg_data;
			if (s_tvalid && s_tready) parse_header_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got_rec.kind       = m_tuser;
				got_rec.first_byte = m_tdata[30:0];
				got_rec.has_first  = m_tdata[31];
				got_rec.last_byte  = m_tdata[62:32];
				got_rec.has_last   = m_tdata[63];
				got_rec.final_res  = m_tlast;
				if (due_records.size() == 0) begin
					report_mismatch("beat with nothing due, kind", 64'(got_rec.kind), '0);
				end else begin
					want_rec = due_records.pop_front();
					if (got_rec.kind !== want_rec.kind)
						report_mismatch("kind", 64'(got_rec.kind), 64'(want_rec.kind));
					if (got_rec.first_byte !== want_rec.first_byte)
						report_mismatch("first_byte", 64'(got_rec.first_byte),
							64'(want_rec.first_byte));
					if (got_rec.has_first !== want_rec.has_first)
						report_mismatch("has_first", 64'(got_rec.has_first),
							64'(want_rec.has_first));
					if (got_rec.last_byte !== want_rec.last_byte)
						report_mismatch("last_byte", 64'(got_rec.last_byte),
							64'(want_rec.last_byte));
					if (got_rec.has_last !== want_rec.has_last)
						report_mismatch("has_last", 64'(got_rec.has_last),
							64'(want_rec.has_last));
					if (got_rec.final_res !== want_rec.final_res)
						report_mismatch("final_res", 64'(got_rec.final_res),
							64'(want_rec.final_res));
				end
				out_beats++;
			end
			records_due <= due_records.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP byte range parser testbench
// Drives short directed headers and then mostly well-formed random range
// headers with some broken and noisy ones, over several position limits,
// with random idle beats on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import hbrp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_ITEMS   = 270;
	localparam int unsigned NUM_PHASES    = 6;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [POS_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [CHAR_W-1:0] s_tdata   = '0;
	logic              s_tlast   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [63:0]       m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic              m_tlast;

	int unsigned       fail_count;
	int unsigned       records_due;
	int unsigned       cycles;
	int unsigned       hold_left;
	int unsigned       idle_left;
	int unsigned       sent;
	bit                quiet;
	bit                hold_go;
	bit                hold_done;
	bit [POS_W-1:0]    cur_limit = LIMIT_RESET;
	bit [CHAR_W-1:0]   hdr[$];

	http_byte_range_parser_unit dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	hbrp_checker u_check (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.fail_count, .records_due
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (idle_left != 0) begin
			idle_left <= idle_left - 1;
			m_tready  <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			idle_left <= $urandom_range(0, 2);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_beat(input bit [CHAR_W-1:0] ch, input bit close);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= close;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (records_due != 0) @(posedge clk);
	endtask

	task automatic write_limit(input bit [POS_W-1:0] value);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_limit = value;
	endtask

	task automatic send_header();
		foreach (hdr[k]) send_beat(hdr[k], 1'b0);
		send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
		sent += hdr.size() + 1;
	endtask

	task automatic send_text(input string text);
		int k;
		hdr.delete();
		for (k = 0; k < text.len(); k++) hdr.push_back(text[k]);
		send_header();
	endtask

	function automatic bit [CHAR_W-1:0] noise_char();
		case ($urandom_range(0, 4))
			0: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
			1: return CH_DASH;
			2: return CH_COMMA;
			3: return CH_SPACE;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic bit [VAL_W-1:0] pick_pos();
		bit [VAL_W-1:0]  v;
		longint unsigned w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = VAL_W'($urandom_range(0, 999));
			5: begin
				v = cur_limit;
				v = v + VAL_W'($urandom_range(0, 4));
				if (v >= 2) v = v - 2;
			end
			6: begin
				v = VAL_W'($urandom);
				v[VAL_W-1:POS_W] = '0;
			end
			7: begin
				w = {$urandom, $urandom};
				v = VAL_W'(w % 64'd10000000000);
			end
			8: v = 34'd2147483647 + VAL_W'($urandom_range(0, 1));
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic void add_number(input bit [VAL_W-1:0] v);
		bit [CHAR_W-1:0] digs[$];
		bit [VAL_W-1:0]  rest;
		bit [CHAR_W-1:0] d;
		rest = v;
		do begin
			d = CHAR_W'(rest % 10);
			digs.push_front(CH_ZERO + d);
			rest = rest / 10;
		end while (rest != 0);
		if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) hdr.push_back(CH_ZERO);
		foreach (digs[k]) hdr.push_back(digs[k]);
	endfunction

	function automatic void build_header();
		int unsigned     nspec;
		int unsigned     shape;
		int unsigned     pos;
		int unsigned     i;
		bit [VAL_W-1:0]  first;
		bit [VAL_W-1:0]  last;
		bit [VAL_W-1:0]  prev_first;
		bit [VAL_W-1:0]  prev_last;
		longint unsigned r;
		hdr.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 10)) hdr.push_back(noise_char());
			return;
		end
		nspec      = $urandom_range(1, 4);
		prev_first = '0;
		prev_last  = '0;
		for (i = 0; i < nspec; i++) begin
			if (i > 0) begin
				hdr.push_back(CH_COMMA);
				if ($urandom_range(0, 7) == 0) hdr.push_back(CH_COMMA);
				if ($urandom_range(0, 2) == 0) hdr.push_back(CH_SPACE);
			end
			shape = $urandom_range(0, 9);
			if (shape < 2 && i + 1 < nspec && $urandom_range(0, 3) != 0) shape = 2;
			if (i == 0 || $urandom_range(0, 7) == 0) begin
				first = pick_pos();
			end else if ($urandom_range(0, 2) == 0) begin
				r = {$urandom, $urandom};
				r = r % (prev_last - prev_first + 1);
				first = prev_first + r[VAL_W-1:0];
			end else begin
				first = prev_last + VAL_W'($urandom_range(1, 500));
			end
			if ($urandom_range(0, 4) == 0) last = pick_pos();
			else last = first + VAL_W'($urandom_range(0, 2000));
			case (shape)
				0: begin
					hdr.push_back(CH_DASH);
					add_number(last);
				end
				1: begin
					add_number(first);
					hdr.push_back(CH_DASH);
				end
				default: begin
					add_number(first);
					hdr.push_back(CH_DASH);
					add_number(last);
				end
			endcase
			prev_first = first;
			prev_last  = (last > first) ? last : first;
		end
		if ($urandom_range(0, 7) == 0) hdr.push_back(CH_COMMA);
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				pos = $urandom_range(0, hdr.size() - 1);
				case ($urandom_range(0, 2))
					0: hdr[pos] = noise_char();
					1: hdr.insert(pos, noise_char());
					default: if (hdr.size() > 1) hdr.delete(pos);
				endcase
			end
		end
	endfunction

	initial begin : stimulus
		bit [POS_W-1:0] limits [NUM_PHASES];
		int unsigned    p;
		int unsigned    phase_start;
		bit             paused;
		limits[0] = LIMIT_RESET;
		limits[1] = '0;
		limits[2] = POS_W'(999);
		limits[3] = POS_W'($urandom);
		limits[4] = POS_W'(65535);
		limits[5] = LIMIT_RESET - 1;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("0-9");
		send_text("-5");
		send_text("5-3");
		send_text("-");
		send_text("7");
		send_text("");
		send_text("1--");
		send_text("1-,2-");
		send_text(",x");

		for (p = 0; p < NUM_PHASES; p++) begin
			write_limit(limits[p]);
			@(posedge clk);
			quiet = (p == NUM_PHASES - 1);
			if (p == 0) hold_go = 1'b1;
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) begin
				if (p == 3 && !paused && sent - phase_start >= PHASE_ITEMS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
				build_header();
				send_header();
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
